// File: sv/dpps_pkg.sv
// Shared types and constants of the deadband position stepper.
`timescale 1ns / 1ps

package dpps_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_TARGET_OFFSET = 3'd0,
      REG_DEADBAND      = 3'd1,
      REG_GAIN_Q16      = 3'd2,
      REG_MAX_STEP_Q8   = 3'd3,
      REG_MIN_STEP_Q8   = 3'd4,
      REG_TIME_SCALE    = 3'd5
   } csr_reg_type;

   localparam logic signed [15:0] TARGET_OFFSET_RST = 16'sd31;
   localparam logic [7:0]         DEADBAND_RST      = 8'd3;
   localparam logic [15:0]        GAIN_Q16_RST      = 16'd3277;
   localparam logic [11:0]        MAX_STEP_Q8_RST   = 12'd1280;
   localparam logic [11:0]        MIN_STEP_Q8_RST   = 12'd77;
   localparam logic [9:0]         TIME_SCALE_RST    = 10'd100;

   localparam logic [15:0] MOVE_TIME_LIMIT = 16'd16384;

endpackage

// File: sv/dpps_req_if.sv
// Input channel of the deadband position stepper.
`timescale 1ns / 1ps

interface dpps_req_if #(parameter int ANGLE_WIDTH = 18);
   logic                          valid;
   logic                          ready;
   logic signed [15:0]            measured_offset;
   logic signed [ANGLE_WIDTH-1:0] start_angle;
   logic [15:0]                   start_time;

   modport source (output valid, measured_offset, start_angle, start_time, input ready);
   modport sink (input valid, measured_offset, start_angle, start_time, output ready);
endinterface

// File: sv/dpps_rsp_if.sv
// Result channel of the deadband position stepper.
`timescale 1ns / 1ps

interface dpps_rsp_if #(parameter int ANGLE_WIDTH = 18);
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] joint_angle;
   logic [15:0]                   move_time;
   logic                          aligned;
   logic                          moved;

   modport source (output valid, joint_angle, move_time, aligned, moved, input ready);
   modport sink (input valid, joint_angle, move_time, aligned, moved, output ready);
endinterface

// File: sv/deadband_p_position_stepper_top.sv
// Deadband proportional position stepper: one joint, one shared multiplier.
//
// Usage:
//   req carries one beat per camera frame: measured_offset, start_angle and
//   start_time. rsp returns exactly one beat per request beat: joint_angle,
//   move_time, aligned and moved. The APB port (psel/penable/pwrite/paddr/
//   pwdata/prdata/pready) holds six registers at byte addresses 0..20; the
//   user must write them only while the block is idle, which the block does
//   not enforce; pready is tied high. The 16x16 multiplier is shared by
//   the gain product and the move-time product, and each beat is
//   sequenced through error multiply, clamp, time multiply and writeback,
//   where the result is registered.
//   req.ready is high only while the sequencer is idle; a new beat may be
//   taken while the previous result still waits on rsp.
//   If rsp stalls, the sequencer holds in writeback until the output
//   register frees, and state is updated only when the result is loaded.
//   Reset restores the register defaults, clears tracking, zeroes the held
//   angle and time and empties the output register.
`timescale 1ns / 1ps

module deadband_p_position_stepper_top
   import dpps_pkg::*;
#(
   parameter int ANGLE_WIDTH = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   dpps_req_if.sink              req,
   dpps_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SW = ((ANGLE_WIDTH > 13) ? ANGLE_WIDTH : 13) + 1;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_MUL_ERR  = 5'b00010,
      ST_CLAMP    = 5'b00100,
      ST_MUL_TIME = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] target_ff;
   logic [7:0]         deadband_ff;
   logic [15:0]        gain_ff;
   logic [11:0]        max_step_ff;
   logic [11:0]        min_step_ff;
   logic [9:0]         time_scale_ff;

   logic                          tracking_ff;
   logic signed [ANGLE_WIDTH-1:0] held_angle_ff;
   logic [15:0]                   held_time_ff;

   logic signed [16:0]            err_ff;
   logic signed [ANGLE_WIDTH-1:0] start_angle_ff;
   logic [15:0]                   start_time_ff;
   logic [31:0]                   prod_ff;
   logic [11:0]                   mag_ff, mag_in;
   logic                          neg_ff;
   logic                          nonzero_ff;
   logic                          aligned_ff;
   logic                          load_ff;
   logic signed [ANGLE_WIDTH-1:0] new_angle_ff, new_angle_in;

   logic                          rsp_valid_ff;
   logic signed [ANGLE_WIDTH-1:0] out_angle_ff;
   logic [15:0]                   out_time_ff;
   logic                          out_aligned_ff;
   logic                          out_moved_ff;

   logic        csr_write;
   csr_reg_type csr_idx;
   logic        req_take;
   logic        out_free;
   logic [16:0] err_abs;
   logic [15:0] emag;
   logic [15:0] mul_a;
   logic [15:0] mul_b;
   logic [31:0] mul_p;
   logic [32:0] rounded;
   logic [24:0] mag_full;
   logic [11:0] mag_lim;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] step;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_idx   = csr_reg_type'(paddr[4:2]);

   always_comb begin
      unique case (csr_idx)
         REG_TARGET_OFFSET: prdata = CSR_DATA_W'(signed'(target_ff));
         REG_DEADBAND:      prdata = CSR_DATA_W'(deadband_ff);
         REG_GAIN_Q16:      prdata = CSR_DATA_W'(gain_ff);
         REG_MAX_STEP_Q8:   prdata = CSR_DATA_W'(max_step_ff);
         REG_MIN_STEP_Q8:   prdata = CSR_DATA_W'(min_step_ff);
         REG_TIME_SCALE:    prdata = CSR_DATA_W'(time_scale_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= TARGET_OFFSET_RST;
         deadband_ff   <= DEADBAND_RST;
         gain_ff       <= GAIN_Q16_RST;
         max_step_ff   <= MAX_STEP_Q8_RST;
         min_step_ff   <= MIN_STEP_Q8_RST;
         time_scale_ff <= TIME_SCALE_RST;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_TARGET_OFFSET: target_ff     <= signed'(pwdata[15:0]);
            REG_DEADBAND:      deadband_ff   <= pwdata[7:0];
            REG_GAIN_Q16:      gain_ff       <= pwdata[15:0];
            REG_MAX_STEP_Q8:   max_step_ff   <= pwdata[11:0];
            REG_MIN_STEP_Q8:   min_step_ff   <= pwdata[11:0];
            REG_TIME_SCALE:    time_scale_ff <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   assign err_abs = err_ff[16] ? 17'(-err_ff) : 17'(err_ff);
   assign emag    = err_abs[15:0];

   assign mul_a = (state_ff == ST_MUL_ERR) ? emag : {4'b0, mag_ff};
   assign mul_b = (state_ff == ST_MUL_ERR) ? gain_ff : {6'b0, time_scale_ff};
   assign mul_p = mul_a * mul_b;

   assign rounded  = {1'b0, prod_ff} + 33'd128;
   assign mag_full = rounded[32:8];
   assign mag_lim  = (mag_full > 25'(max_step_ff)) ? max_step_ff : mag_full[11:0];
   assign mag_in   = (nonzero_ff && (mag_lim < min_step_ff)) ? min_step_ff : mag_lim;

   assign step = neg_ff ? -signed'({{(SW-12){1'b0}}, mag_ff})
                        : signed'({{(SW-12){1'b0}}, mag_ff});
   assign sum  = SW'(held_angle_ff) + step;

   always_comb begin
      if (sum[SW-1:ANGLE_WIDTH-1] != {(SW-ANGLE_WIDTH+1){sum[SW-1]}}) begin
         new_angle_in = sum[SW-1] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      end else begin
         new_angle_in = sum[ANGLE_WIDTH-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_take) state_in = ST_MUL_ERR;
         ST_MUL_ERR:  state_in = ST_CLAMP;
         ST_CLAMP:    state_in = ST_MUL_TIME;
         ST_MUL_TIME: state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         err_ff         <= 17'(target_ff) - 17'(req.measured_offset);
         start_angle_ff <= req.start_angle;
         start_time_ff  <= req.start_time;
      end
      if (state_ff == ST_MUL_ERR) begin
         prod_ff    <= mul_p;
         neg_ff     <= err_ff[16];
         nonzero_ff <= (emag != 16'd0) && (gain_ff != 16'd0);
         aligned_ff <= emag < {8'b0, deadband_ff};
         load_ff    <= !tracking_ff;
      end
      if (state_ff == ST_CLAMP) begin
         mag_ff <= mag_in;
      end
      if (state_ff == ST_MUL_TIME) begin
         prod_ff      <= mul_p;
         new_angle_ff <= new_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff   <= 1'b0;
         held_angle_ff <= '0;
         held_time_ff  <= '0;
      end else if (state_ff == ST_DONE && out_free) begin
         if (aligned_ff) begin
            tracking_ff <= 1'b0;
         end else if (load_ff) begin
            tracking_ff   <= 1'b1;
            held_angle_ff <= start_angle_ff;
            held_time_ff  <= start_time_ff;
         end else begin
            held_angle_ff <= new_angle_ff;
            held_time_ff  <= prod_ff[23:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         out_aligned_ff <= aligned_ff;
         out_moved_ff   <= !aligned_ff && !load_ff;
         priority if (aligned_ff) begin
            out_angle_ff <= held_angle_ff;
            out_time_ff  <= held_time_ff;
         end else if (load_ff) begin
            out_angle_ff <= start_angle_ff;
            out_time_ff  <= start_time_ff;
         end else begin
            out_angle_ff <= new_angle_ff;
            out_time_ff  <= prod_ff[23:8];
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.joint_angle = out_angle_ff;
   assign rsp.move_time   = out_time_ff;
   assign rsp.aligned     = out_aligned_ff;
   assign rsp.moved       = out_moved_ff;

endmodule

// File: sv/dpps_checker.sv
// Port-level checks of the deadband position stepper and their bind.
`timescale 1ns / 1ps

module dpps_checker
   import dpps_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_aligned,
   input logic        rsp_moved,
   input logic [15:0] rsp_move_time
);

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_aligned && rsp_moved))
      else $error("aligned and moved both set");

   a_move_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved |-> rsp_move_time < MOVE_TIME_LIMIT)
      else $error("move time beyond the largest step product");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_move_time))
      else $error("stalled result beat dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind deadband_p_position_stepper_top dpps_checker u_dpps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_aligned   (rsp.aligned),
   .rsp_moved     (rsp.moved),
   .rsp_move_time (rsp.move_time)
);

// File: tb/deadband_p_position_stepper_checker.sv
// Checker for the deadband position stepper: predicts each result beat and compares it.
`timescale 1ns / 1ps

module deadband_p_position_stepper_checker
   import dpps_pkg::*;
#(
   parameter int ANGLE_WIDTH = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   dpps_req_if                   req_mon,
   dpps_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    mismatches,
   output int                    pending
);

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] joint_angle;
      logic [15:0]                   move_time;
      logic                          aligned;
      logic                          moved;
   } joint_result_type;

   localparam longint ANGLE_MAX = (longint'(1) << (ANGLE_WIDTH - 1)) - 1;
   localparam longint ANGLE_MIN = -ANGLE_MAX - 1;

   logic signed [15:0]            target;
   logic [7:0]                    deadband;
   logic [15:0]                   gain;
   logic [11:0]                   max_step;
   logic [11:0]                   min_step;
   logic [9:0]                    time_scale;
   bit                            tracking;
   logic signed [ANGLE_WIDTH-1:0] held_angle;
   logic [15:0]                   held_time;
   joint_result_type              expected_q[$];

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic joint_result_type advance_joint(
      input logic signed [15:0]            meas,
      input logic signed [ANGLE_WIDTH-1:0] start_angle,
      input logic [15:0]                   start_time
   );
      joint_result_type r;
      longint err;
      longint emag;
      longint mag;
      longint sum;
      err  = longint'(target) - longint'(meas);
      emag = (err < 0) ? -err : err;
      r.aligned = 1'b0;
      r.moved   = 1'b0;
      if (emag < longint'(deadband)) begin
         tracking  = 1'b0;
         r.aligned = 1'b1;
      end else if (!tracking) begin
         held_angle = start_angle;
         held_time  = start_time;
         tracking   = 1'b1;
      end else begin
         mag = (emag * longint'(gain) + 128) >> 8;
         if (mag > longint'(max_step)) mag = longint'(max_step);
         if (emag != 0 && gain != 0 && mag < longint'(min_step)) mag = longint'(min_step);
         sum = longint'(held_angle) + ((err < 0) ? -mag : mag);
         if (sum > ANGLE_MAX) sum = ANGLE_MAX;
         if (sum < ANGLE_MIN) sum = ANGLE_MIN;
         held_angle = sum[ANGLE_WIDTH-1:0];
         held_time  = 16'((mag * longint'(time_scale)) >> 8);
         r.moved    = 1'b1;
      end
      r.joint_angle = held_angle;
      r.move_time   = held_time;
      return r;
   endfunction

   always @(posedge clock) begin
      joint_result_type seen;
      joint_result_type want;
      if (reset) begin
         target     = TARGET_OFFSET_RST;
         deadband   = DEADBAND_RST;
         gain       = GAIN_Q16_RST;
         max_step   = MAX_STEP_Q8_RST;
         min_step   = MIN_STEP_Q8_RST;
         time_scale = TIME_SCALE_RST;
         tracking   = 1'b0;
         held_angle = '0;
         held_time  = '0;
         mismatches = 0;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[CSR_ADDR_W-1:2]))
               REG_TARGET_OFFSET: target     = pwdata[15:0];
               REG_DEADBAND:      deadband   = pwdata[7:0];
               REG_GAIN_Q16:      gain       = pwdata[15:0];
               REG_MAX_STEP_Q8:   max_step   = pwdata[11:0];
               REG_MIN_STEP_Q8:   min_step   = pwdata[11:0];
               REG_TIME_SCALE:    time_scale = pwdata[9:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.joint_angle = rsp_mon.joint_angle;
            seen.move_time   = rsp_mon.move_time;
            seen.aligned     = rsp_mon.aligned;
            seen.moved       = rsp_mon.moved;
            if (expected_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_q.pop_front();
               if (seen.joint_angle !== want.joint_angle)
                  report_mismatch($sformatf("joint_angle %0d, expected %0d",
                                            seen.joint_angle, want.joint_angle));
               if (seen.move_time !== want.move_time)
                  report_mismatch($sformatf("move_time %0d, expected %0d",
                                            seen.move_time, want.move_time));
               if (seen.aligned !== want.aligned)
                  report_mismatch($sformatf("aligned %b, expected %b",
                                            seen.aligned, want.aligned));
               if (seen.moved !== want.moved)
                  report_mismatch($sformatf("moved %b, expected %b",
                                            seen.moved, want.moved));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(advance_joint(req_mon.measured_offset,
                                               req_mon.start_angle,
                                               req_mon.start_time));
      end
      pending = expected_q.size();
   end

endmodule

// File: tb/deadband_p_position_stepper_top_tb.sv
// Testbench top for the deadband position stepper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module deadband_p_position_stepper_top_tb;
   import dpps_pkg::*;

   localparam int         ANGLE_WIDTH     = 18;
   localparam int         ANGLE_MAX       = (1 << (ANGLE_WIDTH - 1)) - 1;
   localparam int         ANGLE_MIN       = -ANGLE_MAX - 1;
   localparam logic [2:0] SPARE_REG       = 3'd6;
   localparam int         STALL_LIMIT     = 3000;
   localparam int         HOLD_OFF_CYCLES = 300;
   localparam int         DRAIN_CYCLES    = 10;
   localparam int         PHASES          = 14;
   localparam int         FRAMES_PER_PHASE = 130;

   typedef enum int {
      MIX_RANDOM,
      MIX_ALL_HIGH,
      MIX_ALL_LOW,
      MIX_MIN_OVER_MAX
   } setting_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   int   mismatches;
   int   pending;
   int   quiet_cycles = 0;
   bit   calm = 1'b0;
   int   hold_off_req = 0;
   logic signed [15:0] aim = TARGET_OFFSET_RST;
   logic [7:0]         band = DEADBAND_RST;

   dpps_req_if #(.ANGLE_WIDTH(ANGLE_WIDTH)) req_bus ();
   dpps_rsp_if #(.ANGLE_WIDTH(ANGLE_WIDTH)) rsp_bus ();

   deadband_p_position_stepper_top #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   deadband_p_position_stepper_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      int hold_off_done;
      hold_off_done = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_done != hold_off_req) begin
            hold_off_done = hold_off_req;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready = calm || ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic offer_frame(
      input logic signed [15:0]            meas,
      input logic signed [ANGLE_WIDTH-1:0] angle,
      input logic [15:0]                   start_time
   );
      if (!calm && $urandom_range(99) < 24) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.measured_offset = meas;
      req_bus.start_angle     = angle;
      req_bus.start_time      = start_time;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic offer_random_frame();
      int pick;
      int meas;
      logic signed [ANGLE_WIDTH-1:0] angle;
      pick = $urandom_range(99);
      if (pick < 40)
         meas = int'(aim) + int'($urandom_range(0, 2 * band + 8)) - int'(band) - 4;
      else if (pick < 55)
         meas = int'(aim) + int'($urandom_range(0, 600)) - 300;
      else if (pick < 65)
         meas = $urandom_range(1) ? 32767 : -32768;
      else
         meas = int'($signed(16'($urandom)));
      if (meas > 32767) meas = 32767;
      if (meas < -32768) meas = -32768;
      pick = $urandom_range(99);
      if (pick < 20)
         angle = ANGLE_WIDTH'(ANGLE_MAX - int'($urandom_range(0, 3000)));
      else if (pick < 40)
         angle = ANGLE_WIDTH'(ANGLE_MIN + int'($urandom_range(0, 3000)));
      else
         angle = ANGLE_WIDTH'($urandom);
      offer_frame(16'(meas), angle, 16'($urandom));
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (idx == REG_TARGET_OFFSET) aim = data[15:0];
      else if (idx == REG_DEADBAND) band = data[7:0];
   endtask

   task automatic apply_settings(input setting_mix_type mix);
      case (mix)
         MIX_ALL_HIGH: begin
            csr_write(REG_TARGET_OFFSET, 32'h0000_7FFF);
            csr_write(REG_DEADBAND, 32'h0000_00FF);
            csr_write(REG_GAIN_Q16, 32'h0000_FFFF);
            csr_write(REG_MAX_STEP_Q8, 32'h0000_0FFF);
            csr_write(REG_MIN_STEP_Q8, 32'h0000_0FFF);
            csr_write(REG_TIME_SCALE, 32'h0000_03FF);
         end
         MIX_ALL_LOW: begin
            csr_write(REG_TARGET_OFFSET, 32'hFFFF_8000);
            csr_write(REG_DEADBAND, '0);
            csr_write(REG_GAIN_Q16, '0);
            csr_write(REG_MAX_STEP_Q8, '0);
            csr_write(REG_MIN_STEP_Q8, '0);
            csr_write(REG_TIME_SCALE, '0);
         end
         MIX_MIN_OVER_MAX: begin
            csr_write(REG_TARGET_OFFSET, $urandom);
            csr_write(REG_DEADBAND, $urandom_range(0, 20));
            csr_write(REG_GAIN_Q16, $urandom_range(0, 2000));
            csr_write(REG_MAX_STEP_Q8, $urandom_range(0, 200));
            csr_write(REG_MIN_STEP_Q8, $urandom_range(300, 4095));
            csr_write(REG_TIME_SCALE, $urandom);
         end
         default: begin
            csr_write(REG_TARGET_OFFSET, $urandom);
            csr_write(REG_DEADBAND, $urandom_range(1) ? $urandom : $urandom_range(0, 12));
            csr_write(REG_GAIN_Q16, $urandom_range(1) ? $urandom : $urandom_range(0, 4000));
            csr_write(REG_MAX_STEP_Q8, $urandom);
            csr_write(REG_MIN_STEP_Q8, $urandom_range(1) ? $urandom : $urandom_range(0, 100));
            csr_write(REG_TIME_SCALE, $urandom);
         end
      endcase
   endtask

   initial begin
      setting_mix_type mix;
      req_bus.valid           = 1'b0;
      req_bus.measured_offset = '0;
      req_bus.start_angle     = '0;
      req_bus.start_time      = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: aligned, load at extremes, saturate both ways, minimum step
      offer_frame(TARGET_OFFSET_RST, 0, 0);
      offer_frame(-32768, ANGLE_WIDTH'(ANGLE_MAX), 16'hFFFF);
      offer_frame(-32768, 0, 0);
      offer_frame(32767, 0, 0);
      offer_frame(30, 0, 0);
      offer_frame(20, ANGLE_WIDTH'(ANGLE_MIN), 0);
      offer_frame(32767, ANGLE_WIDTH'(ANGLE_MAX), 16'hFFFF);
      offer_frame(28, 0, 0);
      drain();

      // zero error with zero deadband, zero gain, stray register address
      csr_write(REG_DEADBAND, '0);
      csr_write(REG_GAIN_Q16, '0);
      csr_write(SPARE_REG, 32'hFFFF_FFFF);
      offer_frame(TARGET_OFFSET_RST, 0, 0);
      offer_frame(-5, 0, 0);
      drain();

      // minimum above maximum, full gain and time scale
      csr_write(REG_GAIN_Q16, 32'h0000_FFFF);
      csr_write(REG_MAX_STEP_Q8, 100);
      csr_write(REG_MIN_STEP_Q8, 32'h0000_0FFF);
      csr_write(REG_TIME_SCALE, 32'h0000_03FF);
      offer_frame(0, 0, 0);
      offer_frame(62, 0, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       mix = MIX_ALL_HIGH;
            1:       mix = MIX_ALL_LOW;
            2, 8:    mix = MIX_MIN_OVER_MAX;
            default: mix = MIX_RANDOM;
         endcase
         apply_settings(mix);
         calm = (phase == 6);
         if (phase == 3 || phase == 9) hold_off_req++;
         repeat (FRAMES_PER_PHASE) offer_random_frame();
      end
      drain();

      if (mismatches == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
sv/dpps_pkg.sv
sv/dpps_req_if.sv
sv/dpps_rsp_if.sv
sv/deadband_p_position_stepper_top.sv
sv/dpps_checker.sv
tb/deadband_p_position_stepper_checker.sv
tb/deadband_p_position_stepper_top_tb.sv
